/* rtl/core/multimode_sine_modulator_macros.svh */
// assertion macros for the multimode sine modulator
`ifndef MULTIMODE_SINE_MODULATOR_MACROS_SVH
`define MULTIMODE_SINE_MODULATOR_MACROS_SVH
`ifndef ASSERT_OFF
// clocked assertion, off while reset is held
`define SMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smm assertion failed");
// clocked assertion that also holds during reset
`define SMM_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("smm assertion failed");
`else
`define SMM_ASSERT(lbl, clk, rst_n, prop)
`define SMM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* rtl/core/smm_pkg.sv */
// shared types, constants and sine table generator for the multimode sine modulator
package smm_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
  localparam int ROM_AW = SINE_TABLE_BITS + 1;
  localparam int SINE_W = 15;
  localparam int PHASE_W = 32;
  localparam int PH_ENTRIES = 4;
  localparam int CFG_AW = 5;
  localparam logic [ROM_AW-1:0] ROM_TOP = ROM_AW'(1 << SINE_TABLE_BITS);

  typedef enum logic [1:0] {
    PH_CARRIER = 2'd0,
    PH_SPACE   = 2'd1,
    PH_MARK    = 2'd2,
    PH_FM      = 2'd3
  } ph_sel_t;

  typedef enum logic [2:0] {
    MODE_ASK = 3'd0,
    MODE_FSK = 3'd1,
    MODE_PSK = 3'd2,
    MODE_AM  = 3'd3,
    MODE_FM  = 3'd4,
    MODE_PM  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_CARRIER_STEP   = 3'd0,
    REG_SPACE_STEP     = 3'd1,
    REG_MARK_STEP      = 3'd2,
    REG_DEVIATION_STEP = 3'd3,
    REG_AM_INDEX       = 3'd4,
    REG_PM_INDEX       = 3'd5,
    REG_ASK_LOW        = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] carrier_step;
    logic [31:0] space_step;
    logic [31:0] mark_step;
    logic [31:0] deviation_step;
    logic [14:0] am_index;
    logic [15:0] pm_index;
    logic [14:0] ask_low_amplitude;
  } cfg_t;

  localparam logic [31:0] RST_CARRIER_STEP   = 32'd214748365;
  localparam logic [31:0] RST_SPACE_STEP     = 32'd128849019;
  localparam logic [31:0] RST_MARK_STEP      = 32'd343597384;
  localparam logic [31:0] RST_DEVIATION_STEP = 32'd85899346;
  localparam logic [14:0] RST_AM_INDEX       = 15'd16384;
  localparam logic [15:0] RST_PM_INDEX       = 16'd16384;
  localparam logic [14:0] RST_ASK_LOW        = 15'd9830;

  // quarter-wave entry k: taylor series of sin in q30, scaled to 32767
  function automatic logic [SINE_W-1:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    x  = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd210);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd156);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[SINE_W-1:0];
  endfunction

endpackage

/* rtl/core/smm_cfg_regs.sv */
// apb configuration registers of the multimode sine modulator
module smm_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [smm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output smm_pkg::cfg_t             cfg
);

  smm_pkg::cfg_t    cfg_r;
  smm_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = smm_pkg::reg_idx_t'(paddr[smm_pkg::CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_step      <= smm_pkg::RST_CARRIER_STEP;
      cfg_r.space_step        <= smm_pkg::RST_SPACE_STEP;
      cfg_r.mark_step         <= smm_pkg::RST_MARK_STEP;
      cfg_r.deviation_step    <= smm_pkg::RST_DEVIATION_STEP;
      cfg_r.am_index          <= smm_pkg::RST_AM_INDEX;
      cfg_r.pm_index          <= smm_pkg::RST_PM_INDEX;
      cfg_r.ask_low_amplitude <= smm_pkg::RST_ASK_LOW;
    end else if (wr_en) begin
      case (idx)
        smm_pkg::REG_CARRIER_STEP:   cfg_r.carrier_step      <= pwdata;
        smm_pkg::REG_SPACE_STEP:     cfg_r.space_step        <= pwdata;
        smm_pkg::REG_MARK_STEP:      cfg_r.mark_step         <= pwdata;
        smm_pkg::REG_DEVIATION_STEP: cfg_r.deviation_step    <= pwdata;
        smm_pkg::REG_AM_INDEX:       cfg_r.am_index          <= pwdata[14:0];
        smm_pkg::REG_PM_INDEX:       cfg_r.pm_index          <= pwdata[15:0];
        smm_pkg::REG_ASK_LOW:        cfg_r.ask_low_amplitude <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      smm_pkg::REG_CARRIER_STEP:   prdata = cfg_r.carrier_step;
      smm_pkg::REG_SPACE_STEP:     prdata = cfg_r.space_step;
      smm_pkg::REG_MARK_STEP:      prdata = cfg_r.mark_step;
      smm_pkg::REG_DEVIATION_STEP: prdata = cfg_r.deviation_step;
      smm_pkg::REG_AM_INDEX:       prdata = {17'd0, cfg_r.am_index};
      smm_pkg::REG_PM_INDEX:       prdata = {16'd0, cfg_r.pm_index};
      smm_pkg::REG_ASK_LOW:        prdata = {17'd0, cfg_r.ask_low_amplitude};
      default:                     prdata = '0;
    endcase
  end

endmodule

/* rtl/core/smm_phase_ram.sv */
// phase accumulator memory, one write and one registered read port, zero until written
module smm_phase_ram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  smm_pkg::ph_sel_t           waddr,
  input  logic [smm_pkg::PHASE_W-1:0] wdata,
  input  smm_pkg::ph_sel_t           raddr,
  output logic [smm_pkg::PHASE_W-1:0] rdata
);

  logic [smm_pkg::PHASE_W-1:0] mem [smm_pkg::PH_ENTRIES];
  logic [smm_pkg::PH_ENTRIES-1:0] vld_r;
  logic [smm_pkg::PHASE_W-1:0] rd_q_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

/* rtl/core/smm_sine_rom.sv */
// quarter-wave sine rom with registered read
module smm_sine_rom (
  input  logic                       clk,
  input  logic [smm_pkg::ROM_AW-1:0] addr,
  output logic [smm_pkg::SINE_W-1:0] rdata
);

  logic [smm_pkg::SINE_W-1:0] rom_w [smm_pkg::ROM_DEPTH];
  logic [smm_pkg::SINE_W-1:0] rdata_r;

  genvar k;
  generate
    for (k = 0; k < smm_pkg::ROM_DEPTH; k++) begin : g_rom
      localparam logic [smm_pkg::SINE_W-1:0] ENTRY = smm_pkg::sine_entry(k);
      assign rom_w[k] = ENTRY;
    end
  endgenerate

  always_ff @(posedge clk) begin
    rdata_r <= rom_w[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/multimode_sine_modulator.sv */
// multimode sine modulator top level: sequencer, shared multiplier and output register
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | tdata sample, tuser mode+first, tlast last
//  out_    | output    | out_tvalid/tready  | tdata wave, tlast last_out
//  cfg_    | input     | apb psel/penable   | seven registers at byte address 4*i
//
// each item passes through the accept cycle, a read-modify-write pass over the four phase
// entries (each writing one entry while the next is read), then rom read,
// shared multiply and output load
// reset is synchronous; no clearing pass, the phase memory reads zero until written
// a stalled output holds its item; the next item is accepted while it waits, and the
// sequencer stalls only when a second result is ready before the first is taken
`include "multimode_sine_modulator_macros.svh"
module multimode_sine_modulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // sample[15:0]
  input  logic [3:0]  in_tuser,     // mode[2:0], first[3]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // wave[16:0], zero[23:17]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PH,
    ST_ROM,
    ST_SINE,
    ST_OUT
  } state_t;

  smm_pkg::cfg_t cfg;

  state_t                st_r, st_nxt;
  smm_pkg::ph_sel_t      idx_r, idx_nxt;
  smm_pkg::mode_t        mode_r, mode_nxt;
  logic signed [15:0]    sample_r, sample_nxt;
  logic                  first_r, first_nxt;
  logic                  last_r, last_nxt;
  logic signed [49:0]    prod_r, prod_nxt;
  logic [31:0]           pre_r, pre_nxt;
  logic [31:0]           sphase_r, sphase_nxt;
  logic                  neg_r, neg_nxt;
  logic signed [15:0]    sine_r, sine_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [16:0]           out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_acc;
  logic                  bit_one;
  smm_pkg::mode_t        in_mode;
  logic [31:0]           ram_rdata;
  logic [31:0]           ram_wdata;
  logic                  ram_we;
  smm_pkg::ph_sel_t      ram_raddr;
  logic [31:0]           base;
  logic [31:0]           fm_new;
  logic signed [49:0]    prod_rnd;
  logic signed [32:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [17:0]    amp;
  logic [smm_pkg::SINE_W-1:0] rom_data;
  logic [smm_pkg::ROM_AW-1:0] rom_addr;
  logic [smm_pkg::SINE_TABLE_BITS-1:0] rom_i;
  logic signed [15:0]    mag;
  logic signed [15:0]    sine_now;
  logic                  can_load;

  smm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  smm_phase_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smm_sine_rom u_rom (
    .clk   (clk),
    .addr  (rom_addr),
    .rdata (rom_data)
  );

  assign in_tready  = (st_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign in_mode    = smm_pkg::mode_t'(in_tuser[2:0]);
  assign bit_one    = (sample_r != 16'sd0);
  assign base       = first_r ? '0 : ram_rdata;
  assign fm_new     = base + cfg.carrier_step + pre_r;
  assign prod_rnd   = (prod_r + 50'sd16384) >>> 15;
  assign ram_we     = (st_r == ST_PH);
  assign ram_raddr  = (st_r == ST_IDLE) ? smm_pkg::PH_CARRIER
                                        : smm_pkg::ph_sel_t'(idx_r + 2'd1);
  assign can_load   = !out_valid_r || out_tready;

  // quadrant fold of the phase onto the quarter-wave table
  assign rom_i    = sphase_r[29 -: smm_pkg::SINE_TABLE_BITS];
  assign rom_addr = sphase_r[30] ? (smm_pkg::ROM_TOP - {1'b0, rom_i}) : {1'b0, rom_i};
  assign mag      = $signed({1'b0, rom_data});
  assign sine_now = neg_r ? -mag : mag;

  always_comb begin
    if (mode_r == smm_pkg::MODE_AM) begin
      amp = 18'sd32768 + $signed({pre_r[16], pre_r[16:0]});
    end else begin
      amp = bit_one ? 18'sd32768 : $signed({3'b000, cfg.ask_low_amplitude});
    end
  end

  always_comb begin
    if (st_r == ST_SINE) begin
      mul_a = $signed({{15{amp[17]}}, amp});
      mul_b = $signed({sine_now[15], sine_now});
    end else begin
      case (in_mode)
        smm_pkg::MODE_FM: mul_a = $signed({1'b0, cfg.deviation_step});
        smm_pkg::MODE_AM: mul_a = $signed({18'd0, cfg.am_index});
        default:          mul_a = $signed({17'd0, cfg.pm_index});
      endcase
      mul_b = $signed({in_tdata[15], in_tdata});
    end
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    mode_nxt      = mode_r;
    sample_nxt    = sample_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    pre_nxt       = pre_r;
    sphase_nxt    = sphase_r;
    neg_nxt       = neg_r;
    sine_nxt      = sine_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_wdata     = base;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_mode;
          sample_nxt = $signed(in_tdata);
          first_nxt  = in_tuser[3];
          last_nxt   = in_tlast;
          prod_nxt   = mul_a * mul_b;
          idx_nxt    = smm_pkg::PH_CARRIER;
          st_nxt     = ST_PH;
        end
      end
      ST_PH: begin
        case (idx_r)
          smm_pkg::PH_CARRIER: begin
            ram_wdata = base + cfg.carrier_step;
            pre_nxt   = prod_rnd[31:0];
            if (mode_r inside {smm_pkg::MODE_ASK, smm_pkg::MODE_AM}) begin
              sphase_nxt = base;
            end else if (mode_r == smm_pkg::MODE_PSK) begin
              sphase_nxt = base + (bit_one ? 32'h8000_0000 : 32'h0);
            end else if (mode_r == smm_pkg::MODE_PM) begin
              sphase_nxt = base + {prod_r[30:0], 1'b0};
            end
          end
          smm_pkg::PH_SPACE: begin
            ram_wdata = base + cfg.space_step;
            if (mode_r == smm_pkg::MODE_FSK && !bit_one) begin
              sphase_nxt = base;
            end
          end
          smm_pkg::PH_MARK: begin
            ram_wdata = base + cfg.mark_step;
            if (mode_r == smm_pkg::MODE_FSK && bit_one) begin
              sphase_nxt = base;
            end
          end
          default: begin
            if (mode_r == smm_pkg::MODE_FM) begin
              ram_wdata  = fm_new;
              sphase_nxt = fm_new;
            end
          end
        endcase
        idx_nxt = smm_pkg::ph_sel_t'(idx_r + 2'd1);
        if (idx_r == smm_pkg::PH_FM) begin
          st_nxt = ST_ROM;
        end
      end
      ST_ROM: begin
        neg_nxt = sphase_r[31];
        st_nxt  = ST_SINE;
      end
      ST_SINE: begin
        sine_nxt = sine_now;
        prod_nxt = mul_a * mul_b;
        st_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (can_load) begin
          case (mode_r)
            smm_pkg::MODE_ASK, smm_pkg::MODE_AM: out_data_nxt = prod_rnd[16:0];
            smm_pkg::MODE_FSK, smm_pkg::MODE_PSK,
            smm_pkg::MODE_FM, smm_pkg::MODE_PM:  out_data_nxt = {sine_r[15], sine_r};
            default:                             out_data_nxt = '0;
          endcase
          out_last_nxt  = last_r;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      idx_r       <= smm_pkg::PH_CARRIER;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      sample_r    <= sample_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      prod_r      <= prod_nxt;
      pre_r       <= pre_nxt;
      sphase_r    <= sphase_nxt;
      neg_r       <= neg_nxt;
      sine_r      <= sine_nxt;
      out_data_r  <= out_data_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};
  assign out_tlast  = out_last_r;

  `SMM_ASSERT(a_ph_no_collide, clk, rst_n, (st_r == ST_PH) |-> (ram_raddr != idx_r))
  `SMM_ASSERT(a_accept_starts, clk, rst_n, in_acc |=> (st_r == ST_PH && idx_r == smm_pkg::PH_CARRIER))
  `SMM_ASSERT(a_fm_to_rom, clk, rst_n, (st_r == ST_PH && idx_r == smm_pkg::PH_FM) |=> (st_r == ST_ROM))
  `SMM_ASSERT(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(st_r == ST_OUT))
  `SMM_ASSERT_NR(a_rst_clears, clk, !rst_n |=> (!out_valid_r && st_r == ST_IDLE))

endmodule

/* bench/tb_multimode_sine_modulator.sv */
// self-checking testbench for the multimode sine modulator: predicts every wave sample
`timescale 1ns / 1ps
module tb_multimode_sine_modulator;
  import smm_pkg::*;

  localparam int TBL_N = 1 << SINE_TABLE_BITS;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  typedef struct {
    logic [16:0] wave;
    logic        last;
  } wave_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;     // sample[15:0]
  logic [3:0]  in_tuser = '0;     // mode[2:0], first[3]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // wave[16:0], zero[23:17]
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int quarter_rom [0:TBL_N];
  cfg_t shadow = '{carrier_step: RST_CARRIER_STEP, space_step: RST_SPACE_STEP,
                   mark_step: RST_MARK_STEP, deviation_step: RST_DEVIATION_STEP,
                   am_index: RST_AM_INDEX, pm_index: RST_PM_INDEX,
                   ask_low_amplitude: RST_ASK_LOW};
  logic [31:0] car_acc = '0;
  logic [31:0] spc_acc = '0;
  logic [31:0] mrk_acc = '0;
  logic [31:0] fm_acc = '0;

  wave_item_t wave_expected_q[$];
  wave_item_t want;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  multimode_sine_modulator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  // quarter-wave table, taylor series in q30
  initial begin : build_quarter_wave
    logic [63:0] x, x2, t, s, e;
    for (int k = 0; k <= TBL_N; k++) begin
      x  = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int j = 7; j >= 1; j--) begin
        t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'((2 * j) * (2 * j + 1)));
      end
      s = (x * t) >> 30;
      e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      quarter_rom[k] = int'(e);
    end
  end

  function automatic longint sine_at(logic [31:0] p);
    logic [SINE_TABLE_BITS-1:0] i;
    longint v;
    i = p[29 -: SINE_TABLE_BITS];
    v = p[30] ? longint'(quarter_rom[TBL_N - i]) : longint'(quarter_rom[i]);
    return p[31] ? -v : v;
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic logic [16:0] predict_wave(logic [2:0] mode, logic [15:0] raw,
                                               logic first);
    longint smp;
    longint amp;
    longint wv;
    longint dev;
    longint off;
    bit one;
    smp = longint'($signed(raw));
    one = (raw != 16'd0);
    wv = 0;
    if (first) begin
      car_acc = '0;
      spc_acc = '0;
      mrk_acc = '0;
      fm_acc  = '0;
    end
    case (mode)
      MODE_ASK: begin
        amp = one ? 64'sd32768 : longint'(shadow.ask_low_amplitude);
        wv = round_q15(amp * sine_at(car_acc));
      end
      MODE_FSK: wv = sine_at(one ? mrk_acc : spc_acc);
      MODE_PSK: wv = sine_at(one ? car_acc + 32'h8000_0000 : car_acc);
      MODE_AM: begin
        amp = 64'sd32768 + round_q15(longint'(shadow.am_index) * smp);
        wv = round_q15(amp * sine_at(car_acc));
      end
      MODE_FM: begin
        dev = round_q15(longint'(shadow.deviation_step) * smp);
        fm_acc = fm_acc + shadow.carrier_step + dev[31:0];
        wv = sine_at(fm_acc);
      end
      MODE_PM: begin
        off = longint'(shadow.pm_index) * smp;
        wv = sine_at(car_acc + {off[30:0], 1'b0});
      end
      default: wv = 0;
    endcase
    car_acc += shadow.carrier_step;
    spc_acc += shadow.space_step;
    mrk_acc += shadow.mark_step;
    return wv[16:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side: check each item, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (wave_expected_q.size() == 0) begin
        $error("unexpected item: wave %0d last_out %0b", $signed(out_tdata[16:0]), out_tlast);
        errors++;
      end else begin
        want = wave_expected_q.pop_front();
        results_seen++;
        if (out_tdata[16:0] !== want.wave) begin
          $error("wave mismatch: expected %0d, actual %0d", $signed(want.wave),
                 $signed(out_tdata[16:0]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_out mismatch: expected %0b, actual %0b", want.last, out_tlast);
          errors++;
        end
        if (out_tdata[23:17] !== 7'd0) begin
          $error("pad mismatch: expected 0, actual %0h", out_tdata[23:17]);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (stalls_on) stall_left = pick_gap();
    end
  end

  task automatic send_item(input logic [2:0] mode, input logic [15:0] smp,
                           input logic first, input logic last);
    int n;
    in_tdata  <= smp;
    in_tuser  <= {first, mode};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    wave_expected_q.push_back('{predict_wave(mode, smp, first), last});
    items_sent++;
    n = gaps_on ? pick_gap() : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (wave_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write, then read back through a second transfer
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] stored;
    case (idx)
      REG_CARRIER_STEP:   begin shadow.carrier_step = val; stored = val; end
      REG_SPACE_STEP:     begin shadow.space_step = val; stored = val; end
      REG_MARK_STEP:      begin shadow.mark_step = val; stored = val; end
      REG_DEVIATION_STEP: begin shadow.deviation_step = val; stored = val; end
      REG_AM_INDEX:       begin shadow.am_index = val[14:0]; stored = {17'd0, val[14:0]}; end
      REG_PM_INDEX:       begin shadow.pm_index = val[15:0]; stored = {16'd0, val[15:0]}; end
      default: begin
        shadow.ask_low_amplitude = val[14:0];
        stored = {17'd0, val[14:0]};
      end
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== stored) begin
      $error("%s readback mismatch: expected %0h, actual %0h", idx.name(), stored, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all_regs(input logic [31:0] carrier, input logic [31:0] space,
                              input logic [31:0] mark, input logic [31:0] deviation,
                              input logic [31:0] am, input logic [31:0] pm,
                              input logic [31:0] ask_low);
    write_reg(REG_CARRIER_STEP, carrier);
    write_reg(REG_SPACE_STEP, space);
    write_reg(REG_MARK_STEP, mark);
    write_reg(REG_DEVIATION_STEP, deviation);
    write_reg(REG_AM_INDEX, am);
    write_reg(REG_PM_INDEX, pm);
    write_reg(REG_ASK_LOW, ask_low);
    settings_used++;
  endtask

  // runs of mostly one scheme, usually opened by first and closed by last
  task automatic run_bursts(input int n_items);
    logic [15:0] corner [4] = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
    int run_len;
    int pos;
    int r;
    logic [2:0] run_mode;
    logic [2:0] mode;
    logic [15:0] smp;
    logic first;
    run_len = 0;
    pos = 0;
    run_mode = MODE_ASK;
    for (int i = 0; i < n_items; i++) begin
      if (pos == run_len) begin
        pos = 0;
        run_len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
        run_mode = 3'($urandom_range(5, 0));
      end
      mode = ($urandom_range(99) < 85) ? run_mode : 3'($urandom_range(7, 0));
      r = $urandom_range(99);
      if (r < 20) smp = 16'd0;
      else if (r < 30) smp = corner[$urandom_range(3)];
      else smp = 16'($urandom);
      first = ((pos == 0) && ($urandom_range(9) != 0)) || ($urandom_range(49) == 0);
      send_item(mode, smp, first, pos == run_len - 1);
      pos++;
    end
  endtask

  task automatic test_directed_defaults();
    send_item(MODE_ASK, 16'h0000, 1'b1, 1'b0);
    send_item(MODE_ASK, 16'h7FFF, 1'b0, 1'b0);
    send_item(MODE_ASK, 16'h8000, 1'b0, 1'b0);
    send_item(MODE_FSK, 16'h0000, 1'b0, 1'b0);
    send_item(MODE_FSK, 16'h0001, 1'b0, 1'b0);
    send_item(MODE_FSK, 16'hFFFF, 1'b0, 1'b0);
    send_item(MODE_PSK, 16'h0000, 1'b0, 1'b0);
    send_item(MODE_PSK, 16'h7FFF, 1'b0, 1'b0);
    send_item(MODE_AM, 16'h7FFF, 1'b0, 1'b0);
    send_item(MODE_AM, 16'h8000, 1'b0, 1'b0);
    send_item(MODE_AM, 16'h0000, 1'b0, 1'b0);
    send_item(MODE_FM, 16'h0000, 1'b0, 1'b0);
    send_item(MODE_FM, 16'h7FFF, 1'b0, 1'b0);
    send_item(MODE_FM, 16'h8000, 1'b0, 1'b0);
    send_item(MODE_PM, 16'h7FFF, 1'b0, 1'b0);
    send_item(MODE_PM, 16'h8000, 1'b0, 1'b0);
    send_item(MODE_PM, 16'h0001, 1'b0, 1'b0);
    send_item(MODE_RSVD6, 16'h5555, 1'b0, 1'b0);
    send_item(MODE_RSVD7, 16'hAAAA, 1'b0, 1'b1);
    // restart after fm has advanced
    send_item(MODE_FM, 16'h0064, 1'b1, 1'b0);
    send_item(MODE_PM, 16'hFFFF, 1'b0, 1'b1);
    wait_all_results();
  endtask

  task automatic test_register_extremes();
    set_all_regs('1, '1, '1, '1, '1, '1, '1);
    run_bursts(100);
    wait_all_results();
    set_all_regs('0, '0, '0, '0, '0, '0, '0);
    run_bursts(100);
    wait_all_results();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) begin
        set_all_regs(RST_CARRIER_STEP, RST_SPACE_STEP, RST_MARK_STEP, RST_DEVIATION_STEP,
                     32'(RST_AM_INDEX), 32'(RST_PM_INDEX), 32'(RST_ASK_LOW));
      end else begin
        set_all_regs($urandom, $urandom, $urandom, $urandom >> $urandom_range(20),
                     $urandom, $urandom, $urandom);
      end
      gaps_on = (ph != 2);
      stalls_on = (ph != 2);
      run_bursts(120);
      wait_all_results();
      run_bursts(120);
      wait_all_results();
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_register_extremes();
    test_random_settings();
    wait_all_results();
    $display("%0d items sent, %0d results checked, %0d register settings", items_sent,
             results_seen, settings_used);
    $display("all six schemes plus undefined codes, run restarts, stalls and gaps");
    if (errors == 0 && wave_expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/smm_pkg.sv
rtl/core/smm_cfg_regs.sv
rtl/core/smm_phase_ram.sv
rtl/core/smm_sine_rom.sv
rtl/core/multimode_sine_modulator.sv
bench/tb_multimode_sine_modulator.sv
